// ===== design/pcos_pkg.sv =====
// Shared constants and types for the phase current offset scaler.
// No dependencies; every other design file imports this package.
package pcos_pkg;

   localparam int CAL_ROUNDS  = 2048;   // calibration length, power of two
   localparam int SAMPLE_BITS = 12;
   localparam int GAIN_BITS   = 16;
   localparam int OUT_BITS    = 29;

   localparam int CAL_LOG2 = $clog2(CAL_ROUNDS);
   localparam int SUM_W    = SAMPLE_BITS + CAL_LOG2;
   // signed difference times zero-extended unsigned gain
   localparam int PROD_W   = (SAMPLE_BITS + 1) + (GAIN_BITS + 1);
   localparam int EXT_W    = (PROD_W > OUT_BITS) ? PROD_W : OUT_BITS;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = GAIN_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_A    = 2'd0,
      REG_GAIN_B    = 2'd1,
      REG_GAIN_C    = 2'd2,
      REG_C_PRESENT = 2'd3
   } csr_index_type;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(105);

   typedef logic [SAMPLE_BITS-1:0]     sample_type;
   typedef logic [GAIN_BITS-1:0]       gain_type;
   typedef logic signed [OUT_BITS-1:0] current_type;

   typedef struct packed {
      gain_type gain_a;
      gain_type gain_b;
      gain_type gain_c;
      logic     c_present;
   } cfg_type;

   typedef struct packed {
      sample_type offset_a;
      sample_type offset_b;
      sample_type offset_c;
      logic       calibrated;   // state before the current request
      logic       done;         // current request completes a calibration
   } cal_status_type;

endpackage

// ===== design/pcos_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on pcos_pkg for payload types.
interface pcos_req_if;
   import pcos_pkg::*;
   logic       valid;
   logic       ready;
   logic       func;
   sample_type sample_a;
   sample_type sample_b;
   sample_type sample_c;

   modport source (output valid, func, sample_a, sample_b, sample_c, input ready);
   modport sink   (input valid, func, sample_a, sample_b, sample_c, output ready);
endinterface

interface pcos_rsp_if;
   import pcos_pkg::*;
   logic        valid;
   logic        ready;
   current_type current_a;
   current_type current_b;
   current_type current_c;
   logic        offsets_valid;

   modport source (output valid, current_a, current_b, current_c, offsets_valid,
                   input ready);
   modport sink   (input valid, current_a, current_b, current_c, offsets_valid,
                   output ready);
endinterface

// ===== design/pcos_csr.sv =====
// Configuration registers: per-phase gains and phase C presence.
// Depends on pcos_pkg.
module pcos_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          write_en,
   input  logic [pcos_pkg::CSR_IDX_W-1:0]  index,
   input  logic [pcos_pkg::CSR_DATA_W-1:0] data,
   output pcos_pkg::cfg_type             cfg
);
   import pcos_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_index_type'(index))
            REG_GAIN_A:    cfg_in.gain_a    = data[GAIN_BITS-1:0];
            REG_GAIN_B:    cfg_in.gain_b    = data[GAIN_BITS-1:0];
            REG_GAIN_C:    cfg_in.gain_c    = data[GAIN_BITS-1:0];
            REG_C_PRESENT: cfg_in.c_present = data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_a    <= GAIN_RESET;
         cfg_ff.gain_b    <= GAIN_RESET;
         cfg_ff.gain_c    <= GAIN_RESET;
         cfg_ff.c_present <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ===== design/pcos_cal.sv =====
// Offset calibration: sums samples over CAL_ROUNDS requests, then stores the means.
// Depends on pcos_pkg.
module pcos_cal (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,       // calibration request leaves stage 1
   input  logic                       c_present,
   input  pcos_pkg::sample_type       sample_a,
   input  pcos_pkg::sample_type       sample_b,
   input  pcos_pkg::sample_type       sample_c,
   output pcos_pkg::cal_status_type   status
);
   import pcos_pkg::*;

   localparam logic [CAL_LOG2-1:0] CNT_LAST = CAL_LOG2'(CAL_ROUNDS - 1);

   logic [SUM_W-1:0]    sum_a_ff, sum_b_ff, sum_c_ff;
   logic [SUM_W-1:0]    sum_a_in, sum_b_in, sum_c_in;
   logic [CAL_LOG2-1:0] count_ff, count_in;
   sample_type          offset_a_ff, offset_b_ff, offset_c_ff;
   sample_type          offset_a_in, offset_b_in, offset_c_in;
   logic                calibrated_ff, calibrated_in;
   logic                last;

   assign last = (count_ff == CNT_LAST);

   always_comb begin
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      sum_c_in      = sum_c_ff;
      count_in      = count_ff;
      offset_a_in   = offset_a_ff;
      offset_b_in   = offset_b_ff;
      offset_c_in   = offset_c_ff;
      calibrated_in = calibrated_ff;
      if (fire) begin
         sum_a_in = sum_a_ff + SUM_W'(sample_a);
         sum_b_in = sum_b_ff + SUM_W'(sample_b);
         if (c_present) begin
            sum_c_in = sum_c_ff + SUM_W'(sample_c);
         end
         if (last) begin
            // mean of a power-of-two count is the upper bits of the sum
            offset_a_in   = sum_a_in[SUM_W-1:CAL_LOG2];
            offset_b_in   = sum_b_in[SUM_W-1:CAL_LOG2];
            offset_c_in   = c_present ? sum_c_in[SUM_W-1:CAL_LOG2] : '0;
            sum_a_in      = '0;
            sum_b_in      = '0;
            sum_c_in      = '0;
            count_in      = '0;
            calibrated_in = 1'b1;
         end else begin
            count_in = count_ff + CAL_LOG2'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         sum_c_ff      <= '0;
         count_ff      <= '0;
         offset_a_ff   <= '0;
         offset_b_ff   <= '0;
         offset_c_ff   <= '0;
         calibrated_ff <= 1'b0;
      end else begin
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         sum_c_ff      <= sum_c_in;
         count_ff      <= count_in;
         offset_a_ff   <= offset_a_in;
         offset_b_ff   <= offset_b_in;
         offset_c_ff   <= offset_c_in;
         calibrated_ff <= calibrated_in;
      end
   end

   assign status.offset_a   = offset_a_ff;
   assign status.offset_b   = offset_b_ff;
   assign status.offset_c   = offset_c_ff;
   assign status.calibrated = calibrated_ff;
   assign status.done       = last;
endmodule

// ===== design/pcos_scale.sv =====
// One phase of current scaling: (sample - offset) * gain, saturated to OUT_BITS.
// Depends on pcos_pkg.
module pcos_scale (
   input  pcos_pkg::sample_type  sample,
   input  pcos_pkg::sample_type  offset,
   input  pcos_pkg::gain_type    gain,
   output pcos_pkg::current_type current
);
   import pcos_pkg::*;

   localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'((64'sd1 <<< (OUT_BITS - 1)) - 1);
   localparam logic signed [EXT_W-1:0] OUT_MIN = -OUT_MAX - EXT_W'(1);

   logic signed [SAMPLE_BITS:0] diff;
   logic signed [GAIN_BITS:0]   gain_s;
   logic signed [PROD_W-1:0]    prod;
   logic signed [EXT_W-1:0]     prod_ext;

   always_comb begin
      diff     = signed'({1'b0, sample}) - signed'({1'b0, offset});
      gain_s   = signed'({1'b0, gain});
      prod     = PROD_W'(diff) * PROD_W'(gain_s);
      prod_ext = EXT_W'(prod);
      priority if (prod_ext > OUT_MAX) begin
         current = OUT_MAX[OUT_BITS-1:0];
      end else if (prod_ext < OUT_MIN) begin
         current = OUT_MIN[OUT_BITS-1:0];
      end else begin
         current = prod_ext[OUT_BITS-1:0];
      end
   end
endmodule

// ===== design/phase_current_offset_scaler.sv =====
// Top level: input register, calibration and scaling logic, response register.
// Depends on pcos_pkg, pcos_if, pcos_csr, pcos_cal, pcos_scale.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+------------------------------------------
//   req_ch  | in  | valid/ready       | func, sample_a, sample_b, sample_c
//   rsp_ch  | out | valid/ready       | current_a/b/c, offsets_valid
//   csr_*   | in  | write_en only     | csr_index, csr_data
//
// One request per cycle sustained while rsp_ch.ready holds: input register, then
// one subtract-multiply per phase into the response register.
// Stalls on rsp_ch back up through both registers; req_ch.ready drops only
// when both stages hold a request.
// Synchronous reset clears pipeline valids and calibration state; presets CSRs.
module phase_current_offset_scaler (
   input  logic                            clock,
   input  logic                            reset,
   pcos_req_if.sink                        req_ch,
   pcos_rsp_if.source                      rsp_ch,
   input  logic                            csr_write_en,
   input  logic [pcos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcos_pkg::CSR_DATA_W-1:0] csr_data
);
   import pcos_pkg::*;

   cfg_type        cfg;
   cal_status_type cal;

   logic        s1_valid_ff;
   logic        s1_func_ff;
   sample_type  s1_a_ff, s1_b_ff, s1_c_ff;
   logic        s1_go;
   logic        cal_fire;

   logic        out_valid_ff;
   current_type out_a_ff, out_b_ff, out_c_ff;
   current_type out_a_in, out_b_in, out_c_in;
   logic        out_ov_ff, out_ov_in;
   current_type cur_a, cur_b, cur_c;

   assign s1_go        = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign cal_fire     = s1_go && s1_func_ff;

   pcos_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .write_en (csr_write_en),
      .index    (csr_index),
      .data     (csr_data),
      .cfg      (cfg)
   );

   pcos_cal u_cal (
      .clock     (clock),
      .reset     (reset),
      .fire      (cal_fire),
      .c_present (cfg.c_present),
      .sample_a  (s1_a_ff),
      .sample_b  (s1_b_ff),
      .sample_c  (s1_c_ff),
      .status    (cal)
   );

   pcos_scale u_scale_a (
      .sample (s1_a_ff), .offset (cal.offset_a), .gain (cfg.gain_a), .current (cur_a)
   );
   pcos_scale u_scale_b (
      .sample (s1_b_ff), .offset (cal.offset_b), .gain (cfg.gain_b), .current (cur_b)
   );
   pcos_scale u_scale_c (
      .sample (s1_c_ff), .offset (cal.offset_c), .gain (cfg.gain_c), .current (cur_c)
   );

   always_comb begin
      if (s1_func_ff) begin
         out_a_in  = '0;
         out_b_in  = '0;
         out_c_in  = '0;
         out_ov_in = cal.calibrated || cal.done;   // state after this request
      end else begin
         out_a_in  = cur_a;
         out_b_in  = cur_b;
         out_c_in  = cfg.c_present ? cur_c : '0;
         out_ov_in = cal.calibrated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (s1_go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         s1_func_ff <= req_ch.func;
         s1_a_ff    <= req_ch.sample_a;
         s1_b_ff    <= req_ch.sample_b;
         s1_c_ff    <= req_ch.sample_c;
      end
      if (s1_go) begin
         out_a_ff  <= out_a_in;
         out_b_ff  <= out_b_in;
         out_c_ff  <= out_c_in;
         out_ov_ff <= out_ov_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.current_a     = out_a_ff;
   assign rsp_ch.current_b     = out_b_ff;
   assign rsp_ch.current_c     = out_c_ff;
   assign rsp_ch.offsets_valid = out_ov_ff;
endmodule

// ===== design/pcos_checker.sv =====
// Port-level checks for the phase current offset scaler, bound to the top level.
// Depends on pcos_pkg.
module pcos_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input pcos_pkg::current_type           rsp_current_c,
   input logic                            rsp_offsets_valid,
   input logic                            csr_write_en,
   input logic [pcos_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [pcos_pkg::CSR_DATA_W-1:0] csr_data
);
   import pcos_pkg::*;

   logic [1:0] pending_ff;
   logic       seen_valid_ff;
   logic       c_present_ff;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         seen_valid_ff <= 1'b0;
         c_present_ff  <= 1'b1;
      end else begin
         pending_ff <= pending_ff + 2'(req_acc) - 2'(rsp_acc);
         if (rsp_acc && rsp_offsets_valid) begin
            seen_valid_ff <= 1'b1;
         end
         if (csr_write_en && (csr_index_type'(csr_index) == REG_C_PRESENT)) begin
            c_present_ff <= csr_data[0];
         end
      end
   end

   // no response without a request in flight, at most two in flight
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("response without outstanding request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two requests in flight");

   // once calibrated, offsets stay valid
   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && seen_valid_ff) |-> rsp_offsets_valid)
      else $error("offsets_valid dropped after calibration");

   a_c_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !c_present_ff) |-> (rsp_current_c == '0))
      else $error("phase C current nonzero while absent");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response valid dropped under stall");
endmodule

bind phase_current_offset_scaler pcos_checker u_pcos_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_current_c     (rsp_ch.current_c),
   .rsp_offsets_valid (rsp_ch.offsets_valid),
   .csr_write_en      (csr_write_en),
   .csr_index         (csr_index),
   .csr_data          (csr_data)
);
